// ===== hdl/ilid_pkg.sv =====
`timescale 1ns / 1ps

package ilid_pkg;

  // Field widths of the request and result transfers.
  localparam int REQ_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W = 7;

  // Default list capacity.
  localparam int DEF_CAPACITY = 64;

  // Request codes on the input channel.
  typedef enum logic [REQ_W-1:0] {
    REQ_READ    = 3'd0,
    REQ_INS_HD  = 3'd1,
    REQ_INS_TL  = 3'd2,
    REQ_INS_AT  = 3'd3,
    REQ_DELETE  = 3'd4
  } req_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Classified operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_READ,
    OP_INS_HEAD,
    OP_INS_TAIL,
    OP_INS_AT,
    OP_DELETE,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // Result item as held in the output register.
  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    status_e                 status;
    logic [LEN_W-1:0]        length_now;
  } result_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR
  } back_state_e;

endpackage

// ===== hdl/ilid_front.sv =====
`timescale 1ns / 1ps

module ilid_front (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ilid_pkg::REQ_W-1:0]        req_type_i,
  input  logic [ilid_pkg::POS_W-1:0]        position_i,
  input  logic signed [ilid_pkg::VAL_W-1:0] item_value_i,
  input  logic                              q_ready_i,
  output logic                              push_o,
  output ilid_pkg::cmd_t                    cmd_o
);

  // The front takes a transfer whenever the queue has room.
  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i;

  // Classify the request code; unused codes become a bad operation.
  always_comb begin
    cmd_o.pos   = position_i;
    cmd_o.value = item_value_i;
    unique case (req_type_i)
      ilid_pkg::REQ_READ:   cmd_o.op = ilid_pkg::OP_READ;
      ilid_pkg::REQ_INS_HD: cmd_o.op = ilid_pkg::OP_INS_HEAD;
      ilid_pkg::REQ_INS_TL: cmd_o.op = ilid_pkg::OP_INS_TAIL;
      ilid_pkg::REQ_INS_AT: cmd_o.op = ilid_pkg::OP_INS_AT;
      ilid_pkg::REQ_DELETE: cmd_o.op = ilid_pkg::OP_DELETE;
      default:              cmd_o.op = ilid_pkg::OP_BAD;
    endcase
  end

endmodule

// ===== hdl/ilid_queue.sv =====
`timescale 1ns / 1ps

module ilid_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ilid_pkg::cmd_t cmd_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ilid_pkg::cmd_t cmd_o
);

  // Two-entry queue between the front and the back.
  ilid_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           do_push, do_pop;

  assign ready_o = (fill_q != 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/ilid_back.sv =====
`timescale 1ns / 1ps

module ilid_back #(
  parameter int CAPACITY = ilid_pkg::DEF_CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  ilid_pkg::cmd_t                    q_cmd_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ilid_pkg::VAL_W-1:0] read_value_o,
  output logic [ilid_pkg::STAT_W-1:0]       status_o,
  output logic [ilid_pkg::LEN_W-1:0]        length_now_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;
  localparam int LW = ilid_pkg::LEN_W;
  localparam int VW = ilid_pkg::VAL_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  ilid_pkg::back_state_e state_q, state_d;

  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        ins_q, ins_d;
  logic signed [VW-1:0] value_q, value_d;
  logic                 out_valid_q, out_valid_d;
  ilid_pkg::result_t    out_q, out_d;

  // Entry store with one write and one registered read port.
  logic [VW-1:0]        mem_q [CAPACITY];
  logic [VW-1:0]        rdata_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [VW-1:0]        mem_wdata;

  // Shared conditions for the sequencer.
  logic                 out_free, start;
  logic [PW-1:0]        pos_ext, cnt_ext, ins_pos;
  logic                 rd_ok, del_ok, ins_range, ins_full, is_ins;
  logic [CW-1:0]        idx_dec, idx_inc;
  logic                 ins_more, del_more;

  assign out_free = !out_valid_q || out_ready_i;
  assign start    = (state_q == ilid_pkg::S_IDLE) && q_valid_i && out_free;
  assign pos_ext  = PW'(q_cmd_i.pos);
  assign cnt_ext  = PW'(count_q);
  assign rd_ok    = pos_ext < cnt_ext;
  assign del_ok   = pos_ext < cnt_ext;
  assign is_ins   = (q_cmd_i.op == ilid_pkg::OP_INS_HEAD) ||
                    (q_cmd_i.op == ilid_pkg::OP_INS_TAIL) ||
                    (q_cmd_i.op == ilid_pkg::OP_INS_AT);
  assign ins_range = ins_pos > cnt_ext;
  assign ins_full  = count_q == CAP_CNT;
  assign idx_dec   = idx_q - CW'(1);
  assign idx_inc   = idx_q + CW'(1);
  assign ins_more  = idx_q > ins_q;
  assign del_more  = idx_inc < count_q;

  // Target position of an insert.
  always_comb begin
    case (q_cmd_i.op)
      ilid_pkg::OP_INS_HEAD: ins_pos = '0;
      ilid_pkg::OP_INS_TAIL: ins_pos = cnt_ext;
      default:               ins_pos = pos_ext;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ilid_pkg::S_IDLE: begin
        if (start) begin
          if (q_cmd_i.op == ilid_pkg::OP_READ && rd_ok) begin
            state_d = ilid_pkg::S_RD_WAIT;
          end else if (q_cmd_i.op == ilid_pkg::OP_DELETE && del_ok) begin
            state_d = ilid_pkg::S_DEL_CHK;
          end else if (is_ins && !ins_range && !ins_full) begin
            state_d = ilid_pkg::S_INS_CHK;
          end
        end
      end
      ilid_pkg::S_RD_WAIT: state_d = ilid_pkg::S_IDLE;
      ilid_pkg::S_INS_CHK: state_d = ins_more ? ilid_pkg::S_INS_WR : ilid_pkg::S_IDLE;
      ilid_pkg::S_INS_WR:  state_d = ilid_pkg::S_INS_CHK;
      ilid_pkg::S_DEL_CHK: state_d = del_more ? ilid_pkg::S_DEL_WR : ilid_pkg::S_IDLE;
      ilid_pkg::S_DEL_WR:  state_d = ilid_pkg::S_DEL_CHK;
      default:             state_d = ilid_pkg::S_IDLE;
    endcase
  end

  // Datapath, store control and result loading.
  always_comb begin
    pop_o       = 1'b0;
    count_d     = count_q;
    idx_d       = idx_q;
    ins_d       = ins_q;
    value_d     = value_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_raddr   = pos_ext[AW-1:0];
    mem_wdata   = rdata_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      ilid_pkg::S_IDLE: begin
        if (start) begin
          pop_o   = 1'b1;
          idx_d   = count_q;
          ins_d   = ins_pos[CW-1:0];
          value_d = q_cmd_i.value;
          out_d.read_value = '0;
          out_d.length_now = LW'(count_q);
          out_d.status     = ilid_pkg::STAT_RANGE;
          if (q_cmd_i.op == ilid_pkg::OP_READ) begin
            mem_re = rd_ok;
            out_valid_d = !rd_ok;
          end else if (q_cmd_i.op == ilid_pkg::OP_DELETE) begin
            idx_d = pos_ext[CW-1:0];
            out_valid_d = !del_ok;
          end else if (is_ins) begin
            out_valid_d = ins_range || ins_full;
            if (!ins_range && ins_full) begin
              out_d.status = ilid_pkg::STAT_FULL;
            end
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ilid_pkg::S_RD_WAIT: begin
        out_valid_d      = 1'b1;
        out_d.read_value = rdata_q;
        out_d.status     = ilid_pkg::STAT_DONE;
        out_d.length_now = LW'(count_q);
      end
      ilid_pkg::S_INS_CHK: begin
        if (ins_more) begin
          // Fetch the entry below the hole.
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = ins_q[AW-1:0];
          mem_wdata        = value_q;
          count_d          = count_q + CW'(1);
          out_valid_d      = 1'b1;
          out_d.read_value = '0;
          out_d.status     = ilid_pkg::STAT_DONE;
          out_d.length_now = LW'(count_d);
        end
      end
      ilid_pkg::S_INS_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_dec;
      end
      ilid_pkg::S_DEL_CHK: begin
        if (del_more) begin
          // Fetch the entry above the gap.
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
        end else begin
          count_d          = count_q - CW'(1);
          out_valid_d      = 1'b1;
          out_d.read_value = '0;
          out_d.status     = ilid_pkg::STAT_DONE;
          out_d.length_now = LW'(count_d);
        end
      end
      ilid_pkg::S_DEL_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_inc;
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ilid_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    ins_q   <= ins_d;
    value_q <= value_d;
    out_q   <= out_d;
  end

  // Entry store.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_q.read_value;
  assign status_o     = out_q.status;
  assign length_now_o = out_q.length_now;

endmodule

// ===== hdl/indexed_list_insert_delete_top.sv =====
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a positional store.
// Requests arrive on the in_ channel (req_type_i, position_i, item_value_i) and
// each one gives exactly one result on the out_ channel (read_value_o, status_o,
// length_now_o). Both channels complete a transfer when valid and ready are high.
// The front decodes each request into a two-entry queue; the back carries it out
// against an entry memory with one read and one write port, moving one entry at
// a time by a read and then a write. A rejected request gets its result straight
// from the idle state; a read waits for the registered memory read, and an insert
// or delete shifts the entries past its position before the result. One request
// is in the back at a time.
// Reset clears the entry count and all valid flags; the entry memory itself is
// not cleared, since only positions below the count are ever read.
// When the receiver stalls, the result is held in the output register, the back
// waits before starting the next request, and the queue keeps taking up to two
// further requests.
module indexed_list_insert_delete_top #(
  parameter int CAPACITY = ilid_pkg::DEF_CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ilid_pkg::REQ_W-1:0]        req_type_i,
  input  logic [ilid_pkg::POS_W-1:0]        position_i,
  input  logic signed [ilid_pkg::VAL_W-1:0] item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ilid_pkg::VAL_W-1:0] read_value_o,
  output logic [ilid_pkg::STAT_W-1:0]       status_o,
  output logic [ilid_pkg::LEN_W-1:0]        length_now_o
);

  logic           q_ready, push, pop, q_valid;
  ilid_pkg::cmd_t push_cmd, head_cmd;

  // Request decode.
  ilid_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Queue between front and back.
  ilid_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // List store and sequencer.
  ilid_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .length_now_o (length_now_o)
  );

endmodule

// ===== hdl/ilid_checker.sv =====
`timescale 1ns / 1ps

module ilid_checker #(
  parameter int CAPACITY = ilid_pkg::DEF_CAPACITY
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [ilid_pkg::VAL_W-1:0] read_value_o,
  input logic [ilid_pkg::STAT_W-1:0]       status_o,
  input logic [ilid_pkg::LEN_W-1:0]        length_now_o
);

  localparam logic [ilid_pkg::LEN_W-1:0] CAP_LEN = ilid_pkg::LEN_W'(CAPACITY);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) &&
    $stable(status_o) && $stable(length_now_o))
    else $error("result changed while stalled");

  // A full report always comes with a full list.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ilid_pkg::STAT_FULL |-> length_now_o == CAP_LEN)
    else $error("full status with a list that is not full");

  // Only a successful request carries a read value.
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ilid_pkg::STAT_DONE |-> read_value_o == '0)
    else $error("nonzero read value on a failed request");

  // The reported length never exceeds the capacity of the list.
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_now_o <= CAP_LEN)
    else $error("reported length beyond capacity");

endmodule

bind indexed_list_insert_delete_top ilid_checker #(
  .CAPACITY (CAPACITY)
) u_ilid_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .read_value_o (read_value_o),
  .status_o     (status_o),
  .length_now_o (length_now_o)
);
